/* hw/rtl/itac_pkg.sv */
// ============================================================================
// itac_pkg
// Shared constants, types and helper functions of the infix to three-address
// code translator.
// ============================================================================
package itac_pkg;

    localparam int OPERAND_DEPTH  = 32;
    localparam int OPERATOR_DEPTH = 32;

    localparam int OPND_AW = $clog2(OPERAND_DEPTH);
    localparam int OPND_CW = $clog2(OPERAND_DEPTH + 1);
    localparam int OPR_AW  = $clog2(OPERATOR_DEPTH);
    localparam int OPR_CW  = $clog2(OPERATOR_DEPTH + 1);

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_UC_LO  = 8'h41;
    localparam logic [7:0] CH_UC_HI  = 8'h5A;
    localparam logic [7:0] CH_LC_LO  = 8'h61;
    localparam logic [7:0] CH_LC_HI  = 8'h7A;

    localparam logic [1:0] KIND_INSN  = 2'd0;
    localparam logic [1:0] KIND_FINAL = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] dest_temp;
        logic       left_is_temp;
        logic [7:0] left_value;
        logic [7:0] op_char;
        logic       right_is_temp;
        logic [7:0] right_value;
        logic [7:0] target_var;
        logic       last_of_run;
    } result_t;

    // sequencer -> output buffer
    typedef struct packed {
        logic    push;
        logic    close;
        result_t data;
    } ob_cmd_t;

    // output buffer -> sequencer
    typedef struct packed {
        logic can_push;
        logic out_free;
        logic pend_valid;
    } ob_stat_t;

    function automatic logic [1:0] prec(input logic [7:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_PLUS || c == CH_MINUS)
        begin
            p = 2'd1;
        end
        else if (c == CH_STAR || c == CH_SLASH)
        begin
            p = 2'd2;
        end
        return p;
    endfunction

    function automatic logic is_operand(input logic [7:0] c);
        return (c >= CH_DIG_LO && c <= CH_DIG_HI) ||
               (c >= CH_UC_LO && c <= CH_UC_HI) ||
               (c >= CH_LC_LO && c <= CH_LC_HI);
    endfunction

endpackage

/* hw/rtl/itac_if.sv */
// ============================================================================
// itac_if
// Valid/ready channels: symbol input and result output.
// ============================================================================
interface itac_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       is_last;

    modport source (output valid, output symbol, output is_last, input ready);
    modport sink   (input valid, input symbol, input is_last, output ready);
endinterface

interface itac_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] dest_temp;
    logic       left_is_temp;
    logic [7:0] left_value;
    logic [7:0] op_char;
    logic       right_is_temp;
    logic [7:0] right_value;
    logic [7:0] target_var;
    logic       last_of_run;

    modport source (output valid, output kind, output dest_temp, output left_is_temp,
                    output left_value, output op_char, output right_is_temp,
                    output right_value, output target_var, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input dest_temp, input left_is_temp,
                    input left_value, input op_char, input right_is_temp,
                    input right_value, input target_var, input last_of_run,
                    output ready);
endinterface

/* hw/rtl/itac_ram.sv */
// ============================================================================
// itac_ram
// Stack memory: one write port, two read ports, registered read data.
// ============================================================================
module itac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* hw/rtl/itac_obuf.sv */
// ============================================================================
// itac_obuf
// Result buffer: a holding slot whose last_of_run is settled once the next
// result or the end of the transaction is known, then the output register.
// ============================================================================
module itac_obuf (
    input  logic               clk,
    input  logic               rst_n,
    input  itac_pkg::ob_cmd_t  cmd,
    output itac_pkg::ob_stat_t stat,
    output logic               out_valid,
    output itac_pkg::result_t  out_data,
    input  logic               out_ready
);

    logic              pend_valid_reg;
    logic              pend_valid_next;
    itac_pkg::result_t pend_reg;
    itac_pkg::result_t pend_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    itac_pkg::result_t out_reg;
    itac_pkg::result_t out_next;
    logic              out_free;

    assign out_free        = !out_valid_reg || out_ready;
    assign stat.out_free   = out_free;
    assign stat.can_push   = !pend_valid_reg || out_free;
    assign stat.pend_valid = pend_valid_reg;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.push && pend_valid_reg)
        begin
            out_next       = pend_reg;
            out_valid_next = 1'b1;
        end
        else if (cmd.close && pend_valid_reg)
        begin
            out_next             = pend_reg;
            out_next.last_of_run = 1'b1;
            out_valid_next       = 1'b1;
            pend_valid_next      = 1'b0;
        end
        if (cmd.push)
        begin
            pend_next       = cmd.data;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

/* hw/rtl/itac_seq.sv */
// ============================================================================
// itac_seq
// Shunting-yard sequencer around the operand and operator stack memories.
// Each reduction reads the stack tops, then emits and writes back.
// ============================================================================
module itac_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         in_symbol,
    input  logic               in_last,
    output logic               in_ready,
    output itac_pkg::ob_cmd_t  ob_cmd,
    input  itac_pkg::ob_stat_t ob_stat
);

    localparam int OAW = itac_pkg::OPND_AW;
    localparam int OCW = itac_pkg::OPND_CW;
    localparam int PAW = itac_pkg::OPR_AW;
    localparam int PCW = itac_pkg::OPR_CW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_RD     = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_FINAL  = 3'd4;
    localparam logic [2:0] S_ERROR  = 3'd5;
    localparam logic [2:0] S_DRAIN  = 3'd6;

    localparam logic [1:0] M_CLOSE = 2'd0;
    localparam logic [1:0] M_OPER  = 2'd1;
    localparam logic [1:0] M_FLUSH = 2'd2;

    logic [2:0]     state_reg, state_next;
    logic [1:0]     mode_reg, mode_next;
    logic [1:0]     pos_reg, pos_next;
    logic [7:0]     target_reg, target_next;
    logic [OCW-1:0] opnd_cnt_reg, opnd_cnt_next;
    logic [PCW-1:0] opr_cnt_reg, opr_cnt_next;
    logic [7:0]     temp_reg, temp_next;
    logic           err_reg, err_next;
    logic [7:0]     sym_reg, sym_next;
    logic           last_reg, last_next;

    logic [OCW-1:0] opnd_dec1, opnd_dec2;
    logic [PCW-1:0] opr_dec1;
    logic           opnd_full, opr_full;
    logic           do_reduce, item_done, clear;

    logic           opnd_we, opnd_re;
    logic [OAW-1:0] opnd_waddr, opnd_raddr_a, opnd_raddr_b;
    logic [8:0]     opnd_wdata, opnd_rdata_a, opnd_rdata_b;
    logic           opr_we, opr_re;
    logic [PAW-1:0] opr_waddr, opr_raddr;
    logic [7:0]     opr_wdata, opr_rdata;

    assign opnd_dec1 = opnd_cnt_reg - OCW'(1);
    assign opnd_dec2 = opnd_cnt_reg - OCW'(2);
    assign opr_dec1  = opr_cnt_reg - PCW'(1);
    assign opnd_full = (opnd_cnt_reg == OCW'(itac_pkg::OPERAND_DEPTH));
    assign opr_full  = (opr_cnt_reg == PCW'(itac_pkg::OPERATOR_DEPTH));

    itac_ram #(
        .WIDTH (9),
        .DEPTH (itac_pkg::OPERAND_DEPTH)
    ) u_opnd_ram (
        .clk     (clk),
        .we      (opnd_we),
        .waddr   (opnd_waddr),
        .wdata   (opnd_wdata),
        .re      (opnd_re),
        .raddr_a (opnd_raddr_a),
        .raddr_b (opnd_raddr_b),
        .rdata_a (opnd_rdata_a),
        .rdata_b (opnd_rdata_b)
    );

    itac_ram #(
        .WIDTH (8),
        .DEPTH (itac_pkg::OPERATOR_DEPTH)
    ) u_opr_ram (
        .clk     (clk),
        .we      (opr_we),
        .waddr   (opr_waddr),
        .wdata   (opr_wdata),
        .re      (opr_re),
        .raddr_a (opr_raddr),
        .raddr_b (opr_raddr),
        .rdata_a (opr_rdata),
        .rdata_b ()
    );

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        target_next   = target_reg;
        opnd_cnt_next = opnd_cnt_reg;
        opr_cnt_next  = opr_cnt_reg;
        temp_next     = temp_reg;
        err_next      = err_reg;
        sym_next      = sym_reg;
        last_next     = last_reg;
        do_reduce     = 1'b0;
        item_done     = 1'b0;
        clear         = 1'b0;
        in_ready      = (state_reg == S_IDLE);
        ob_cmd        = '0;

        opnd_we      = 1'b0;
        opnd_waddr   = opnd_cnt_reg[OAW-1:0];
        opnd_wdata   = {1'b0, sym_reg};
        opnd_re      = 1'b0;
        opnd_raddr_a = opnd_dec1[OAW-1:0];
        opnd_raddr_b = opnd_dec2[OAW-1:0];
        opr_we       = 1'b0;
        opr_waddr    = opr_cnt_reg[PAW-1:0];
        opr_wdata    = sym_reg;
        opr_re       = 1'b0;
        opr_raddr    = opr_dec1[PAW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sym_next   = in_symbol;
                    last_next  = in_last;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (err_reg)
                begin
                    clear      = last_reg;
                    state_next = S_IDLE;
                end
                else if (pos_reg == 2'd0)
                begin
                    target_next = sym_reg;
                    pos_next    = 2'd1;
                    state_next  = last_reg ? S_FINAL : S_IDLE;
                end
                else if (pos_reg == 2'd1)
                begin
                    pos_next   = 2'd2;
                    state_next = last_reg ? S_FINAL : S_IDLE;
                end
                else if (itac_pkg::is_operand(sym_reg))
                begin
                    if (opnd_full)
                    begin
                        state_next = S_ERROR;
                    end
                    else
                    begin
                        opnd_we       = 1'b1;
                        opnd_cnt_next = opnd_cnt_reg + OCW'(1);
                        item_done     = 1'b1;
                    end
                end
                else if (sym_reg == itac_pkg::CH_LPAREN)
                begin
                    if (opr_full)
                    begin
                        state_next = S_ERROR;
                    end
                    else
                    begin
                        opr_we       = 1'b1;
                        opr_cnt_next = opr_cnt_reg + PCW'(1);
                        item_done    = 1'b1;
                    end
                end
                else if (sym_reg == itac_pkg::CH_RPAREN)
                begin
                    mode_next  = M_CLOSE;
                    state_next = S_RD;
                end
                else
                begin
                    mode_next  = M_OPER;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (opr_cnt_reg == '0)
                begin
                    case (mode_reg)
                        M_CLOSE:
                        begin
                            item_done = 1'b1;
                        end
                        M_OPER:
                        begin
                            if (opr_full)
                            begin
                                state_next = S_ERROR;
                            end
                            else
                            begin
                                opr_we       = 1'b1;
                                opr_cnt_next = opr_cnt_reg + PCW'(1);
                                item_done    = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINAL;
                        end
                    endcase
                end
                else
                begin
                    opnd_re    = 1'b1;
                    opr_re     = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                case (mode_reg)
                    M_CLOSE:
                    begin
                        if (opr_rdata == itac_pkg::CH_LPAREN)
                        begin
                            opr_cnt_next = opr_dec1;
                            item_done    = 1'b1;
                        end
                        else
                        begin
                            do_reduce = 1'b1;
                        end
                    end
                    M_OPER:
                    begin
                        if (opr_rdata != itac_pkg::CH_LPAREN &&
                            itac_pkg::prec(opr_rdata) >= itac_pkg::prec(sym_reg))
                        begin
                            do_reduce = 1'b1;
                        end
                        else if (opr_full)
                        begin
                            state_next = S_ERROR;
                        end
                        else
                        begin
                            opr_we       = 1'b1;
                            opr_cnt_next = opr_cnt_reg + PCW'(1);
                            item_done    = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (opr_rdata == itac_pkg::CH_LPAREN)
                        begin
                            opr_cnt_next = opr_dec1;
                            state_next   = S_RD;
                        end
                        else
                        begin
                            do_reduce = 1'b1;
                        end
                    end
                endcase
                if (do_reduce)
                begin
                    if (opnd_cnt_reg < OCW'(2) || temp_reg == 8'd0)
                    begin
                        state_next = S_ERROR;
                    end
                    else if (ob_stat.can_push)
                    begin
                        ob_cmd.push               = 1'b1;
                        ob_cmd.data.kind          = itac_pkg::KIND_INSN;
                        ob_cmd.data.dest_temp     = temp_reg;
                        ob_cmd.data.left_is_temp  = opnd_rdata_b[8];
                        ob_cmd.data.left_value    = opnd_rdata_b[7:0];
                        ob_cmd.data.op_char       = opr_rdata;
                        ob_cmd.data.right_is_temp = opnd_rdata_a[8];
                        ob_cmd.data.right_value   = opnd_rdata_a[7:0];
                        opnd_we       = 1'b1;
                        opnd_waddr    = opnd_dec2[OAW-1:0];
                        opnd_wdata    = {1'b1, temp_reg};
                        opnd_cnt_next = opnd_dec1;
                        opr_cnt_next  = opr_dec1;
                        temp_next     = temp_reg + 8'd1;
                        state_next    = S_RD;
                    end
                end
            end
            S_FINAL:
            begin
                if (ob_stat.can_push)
                begin
                    ob_cmd.push             = 1'b1;
                    ob_cmd.data.kind        = itac_pkg::KIND_FINAL;
                    ob_cmd.data.dest_temp   = temp_reg - 8'd1;
                    ob_cmd.data.target_var  = target_reg;
                    ob_cmd.data.last_of_run = 1'b1;
                    clear                   = 1'b1;
                    state_next              = S_DRAIN;
                end
            end
            S_ERROR:
            begin
                if (ob_stat.can_push)
                begin
                    ob_cmd.push             = 1'b1;
                    ob_cmd.data.kind        = itac_pkg::KIND_ERROR;
                    ob_cmd.data.last_of_run = 1'b1;
                    err_next                = 1'b1;
                    clear                   = last_reg;
                    state_next              = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!ob_stat.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (ob_stat.out_free)
                begin
                    ob_cmd.close = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (item_done)
        begin
            if (last_reg)
            begin
                mode_next  = M_FLUSH;
                state_next = S_RD;
            end
            else
            begin
                state_next = ob_stat.pend_valid ? S_DRAIN : S_IDLE;
            end
        end

        if (clear)
        begin
            pos_next      = 2'd0;
            target_next   = 8'd0;
            opnd_cnt_next = '0;
            opr_cnt_next  = '0;
            temp_next     = 8'd1;
            err_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= M_CLOSE;
            pos_reg      <= 2'd0;
            target_reg   <= 8'd0;
            opnd_cnt_reg <= '0;
            opr_cnt_reg  <= '0;
            temp_reg     <= 8'd1;
            err_reg      <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            target_reg   <= target_next;
            opnd_cnt_reg <= opnd_cnt_next;
            opr_cnt_reg  <= opr_cnt_next;
            temp_reg     <= temp_next;
            err_reg      <= err_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
    end

endmodule

/* hw/rtl/infix_to_three_address_code.sv */
// ============================================================================
// infix_to_three_address_code
// Translates an assignment such as A=B+C*D, one character per transaction,
// into three-address instructions with shunting-yard evaluation.
// ============================================================================
// Usage:
//   sym : symbol (ASCII) and is_last per transaction. The first character is
//         the target, the second is skipped; is_last starts the final flush.
//   res : one result per transaction: instruction, final assignment or error;
//         last_of_run marks the final result caused by an input transaction.
// Sequence:
//   An operand or an open parenthesis is pushed in the decode state; an operator
//   or a close parenthesis goes on to read the stack tops and, if the operator
//   stack is not empty, to evaluate them. Each reduction reads the stack tops
//   (registered read data), then emits and writes back. An input that produced
//   results passes the drain state to release its last result.
// Reset:
//   Both stacks empty, temps restart at 1, no result pending. The stack
//   memories need no clearing pass; an entry read before a write is never used.
// Stalls:
//   Results pass a holding slot and an output register. When res.ready stays
//   low with both full, the sequencer waits; sym.ready is low until the
//   current input is done.
// ============================================================================
module infix_to_three_address_code (
    input  logic       clk,
    input  logic       rst_n,
    itac_sym_if.sink   sym,
    itac_res_if.source res
);

    itac_pkg::ob_cmd_t  ob_cmd;
    itac_pkg::ob_stat_t ob_stat;
    itac_pkg::result_t  out_data;
    logic               out_valid;

    itac_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sym.valid),
        .in_symbol (sym.symbol),
        .in_last   (sym.is_last),
        .in_ready  (sym.ready),
        .ob_cmd    (ob_cmd),
        .ob_stat   (ob_stat)
    );

    itac_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ob_cmd),
        .stat      (ob_stat),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_ready (res.ready)
    );

    assign res.valid         = out_valid;
    assign res.kind          = out_data.kind;
    assign res.dest_temp     = out_data.dest_temp;
    assign res.left_is_temp  = out_data.left_is_temp;
    assign res.left_value    = out_data.left_value;
    assign res.op_char       = out_data.op_char;
    assign res.right_is_temp = out_data.right_is_temp;
    assign res.right_value   = out_data.right_value;
    assign res.target_var    = out_data.target_var;
    assign res.last_of_run   = out_data.last_of_run;

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ob_cmd.push && ob_cmd.close))
        else $error("push and close together");

    a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (sym.valid && sym.ready) |-> !ob_stat.pend_valid)
        else $error("input accepted with a result still held");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.kind == itac_pkg::KIND_FINAL ||
                       res.kind == itac_pkg::KIND_ERROR)) |-> res.last_of_run)
        else $error("final or error result without last_of_run");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ob_cmd.push |-> ob_stat.can_push)
        else $error("result pushed into a full buffer");

endmodule

/* dv/tb_top.sv */
// ============================================================================
// tb_top
// Self-checking bench for the infix to three-address code translator.
// Sends assignment strings one character per transaction. A scoreboard runs
// its own shunting-yard translation of every accepted character and checks
// each result, field by field and in order. The stimulus has three parts:
//   - short hand-written expressions
//   - stack overflow runs
//   - random expressions: well-formed, broken and pure noise
// Both channels idle in random bursts until the random part passes CALM_AFTER characters.
// ============================================================================
module tb_top;

    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 255;
    localparam int CALM_AFTER = 200;

    class tac_scoreboard;
        int                  position;
        logic [7:0]          target;
        logic [8:0]          opnd_stack[itac_pkg::OPERAND_DEPTH];
        int                  opnd_cnt;
        logic [7:0]          opr_stack[itac_pkg::OPERATOR_DEPTH];
        int                  opr_cnt;
        logic [7:0]          temp_ctr;
        bit                  err_seen;
        itac_pkg::result_t   step_out[$];
        itac_pkg::result_t   expected_tac[$];
        int                  errors;
        int                  n_insn;
        int                  n_final;
        int                  n_fault;

        function new();
            errors = 0;
            n_insn = 0;
            n_final = 0;
            n_fault = 0;
            clear_expr();
        endfunction

        function void clear_expr();
            position = 0;
            target = 8'h00;
            opnd_cnt = 0;
            opr_cnt = 0;
            temp_ctr = 8'd1;
            err_seen = 1'b0;
        endfunction

        static function bit is_var_char(logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function int rank(logic [7:0] c);
            if (c == itac_pkg::CH_PLUS || c == itac_pkg::CH_MINUS)
            begin
                return 1;
            end
            if (c == itac_pkg::CH_STAR || c == itac_pkg::CH_SLASH)
            begin
                return 2;
            end
            return 0;
        endfunction

        function void emit(logic [1:0] kind, logic [7:0] dest, logic [8:0] lhs, logic [7:0] op,
                           logic [8:0] rhs, logic [7:0] tgt);
            itac_pkg::result_t r;
            r = '0;
            r.kind = kind;
            r.dest_temp = dest;
            r.left_is_temp = lhs[8];
            r.left_value = lhs[7:0];
            r.op_char = op;
            r.right_is_temp = rhs[8];
            r.right_value = rhs[7:0];
            r.target_var = tgt;
            step_out.push_back(r);
        endfunction

        function bit reduce_top();
            logic [8:0] lhs;
            logic [8:0] rhs;
            logic [7:0] op;
            if (opnd_cnt < 2 || opr_cnt == 0 || temp_ctr == 8'd0)
            begin
                return 1'b0;
            end
            rhs = opnd_stack[opnd_cnt - 1];
            lhs = opnd_stack[opnd_cnt - 2];
            op = opr_stack[opr_cnt - 1];
            opnd_cnt -= 2;
            opr_cnt--;
            emit(itac_pkg::KIND_INSN, temp_ctr, lhs, op, rhs, 8'h00);
            opnd_stack[opnd_cnt] = {1'b1, temp_ctr};
            opnd_cnt++;
            temp_ctr = temp_ctr + 8'd1;
            return 1'b1;
        endfunction

        function bit shunt(logic [7:0] c);
            if (is_var_char(c))
            begin
                if (opnd_cnt >= itac_pkg::OPERAND_DEPTH)
                begin
                    return 1'b0;
                end
                opnd_stack[opnd_cnt] = {1'b0, c};
                opnd_cnt++;
                return 1'b1;
            end
            if (c == itac_pkg::CH_LPAREN)
            begin
                if (opr_cnt >= itac_pkg::OPERATOR_DEPTH)
                begin
                    return 1'b0;
                end
                opr_stack[opr_cnt] = c;
                opr_cnt++;
                return 1'b1;
            end
            if (c == itac_pkg::CH_RPAREN)
            begin
                while (opr_cnt > 0 && opr_stack[opr_cnt - 1] != itac_pkg::CH_LPAREN)
                begin
                    if (!reduce_top())
                    begin
                        return 1'b0;
                    end
                end
                if (opr_cnt > 0)
                begin
                    opr_cnt--;
                end
                return 1'b1;
            end
            while (opr_cnt > 0 && opr_stack[opr_cnt - 1] != itac_pkg::CH_LPAREN &&
                   rank(opr_stack[opr_cnt - 1]) >= rank(c))
            begin
                if (!reduce_top())
                begin
                    return 1'b0;
                end
            end
            if (opr_cnt >= itac_pkg::OPERATOR_DEPTH)
            begin
                return 1'b0;
            end
            opr_stack[opr_cnt] = c;
            opr_cnt++;
            return 1'b1;
        endfunction

        function bit flush_ops();
            while (opr_cnt > 0)
            begin
                if (opr_stack[opr_cnt - 1] == itac_pkg::CH_LPAREN)
                begin
                    opr_cnt--;
                end
                else if (!reduce_top())
                begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void take_symbol(logic [7:0] c, bit last);
            bit ok;
            ok = 1'b1;
            step_out.delete();
            if (err_seen)
            begin
                if (last)
                begin
                    clear_expr();
                end
                return;
            end
            if (position == 0)
            begin
                target = c;
                position = 1;
            end
            else if (position == 1)
            begin
                position = 2;
            end
            else
            begin
                ok = shunt(c);
            end
            if (ok && last)
            begin
                ok = flush_ops();
            end
            if (!ok)
            begin
                emit(itac_pkg::KIND_ERROR, 8'h00, 9'h000, 8'h00, 9'h000, 8'h00);
                err_seen = 1'b1;
            end
            else if (last)
            begin
                emit(itac_pkg::KIND_FINAL, temp_ctr - 8'd1, 9'h000, 8'h00, 9'h000, target);
            end
            if (step_out.size() > 0)
            begin
                step_out[step_out.size() - 1].last_of_run = 1'b1;
            end
            foreach (step_out[i])
            begin
                expected_tac.push_back(step_out[i]);
            end
            if (last)
            begin
                clear_expr();
            end
        endfunction

        function bit field_ok(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $display("%0t: mismatch in %s, expected %0h, got %0h", $time, name, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_tac(itac_pkg::result_t got);
            itac_pkg::result_t want;
            bit ok;
            if (expected_tac.size() == 0)
            begin
                $display("%0t: result with nothing expected, kind %0d dest %0h",
                         $time, got.kind, got.dest_temp);
                errors++;
                return;
            end
            want = expected_tac.pop_front();
            ok = field_ok("kind", 8'(want.kind), 8'(got.kind));
            ok &= field_ok("dest_temp", want.dest_temp, got.dest_temp);
            ok &= field_ok("left_is_temp", 8'(want.left_is_temp), 8'(got.left_is_temp));
            ok &= field_ok("left_value", want.left_value, got.left_value);
            ok &= field_ok("op_char", want.op_char, got.op_char);
            ok &= field_ok("right_is_temp", 8'(want.right_is_temp), 8'(got.right_is_temp));
            ok &= field_ok("right_value", want.right_value, got.right_value);
            ok &= field_ok("target_var", want.target_var, got.target_var);
            ok &= field_ok("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
            if (!ok)
            begin
                errors++;
            end
            case (want.kind)
                itac_pkg::KIND_INSN:  n_insn++;
                itac_pkg::KIND_FINAL: n_final++;
                default:              n_fault++;
            endcase
        endfunction

        function int outstanding();
            return expected_tac.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    itac_sym_if sym_if();
    itac_res_if res_if();

    infix_to_three_address_code dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sym   (sym_if),
        .res   (res_if)
    );

    tac_scoreboard sb;
    logic [7:0]    expr_buf[$];
    bit            idle_on;
    int            n_sent;
    int            n_expr;
    int            stall_left;
    int            quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // result side backpressure
    initial
    begin
        res_if.ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res_if.ready <= 1'b0;
                stall_left = $urandom_range(1, 3) - 1;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // sample between edges; watchdog
    always @(negedge clk)
    begin : mon
        itac_pkg::result_t got;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                got.kind = res_if.kind;
                got.dest_temp = res_if.dest_temp;
                got.left_is_temp = res_if.left_is_temp;
                got.left_value = res_if.left_value;
                got.op_char = res_if.op_char;
                got.right_is_temp = res_if.right_is_temp;
                got.right_value = res_if.right_value;
                got.target_var = res_if.target_var;
                got.last_of_run = res_if.last_of_run;
                sb.check_tac(got);
            end
            if ((sym_if.valid && sym_if.ready) || (res_if.valid && res_if.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, sb.outstanding());
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    task automatic send_symbol(logic [7:0] c, bit last);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            sym_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        sym_if.valid <= 1'b1;
        sym_if.symbol <= c;
        sym_if.is_last <= last;
        do
        begin
            @(negedge clk);
        end
        while (!sym_if.ready);
        @(posedge clk);
        sb.take_symbol(c, last);
        n_sent++;
    endtask

    task automatic send_expr(bit noisy);
        bit last;
        foreach (expr_buf[i])
        begin
            last = (i == expr_buf.size() - 1) || (noisy && $urandom_range(0, 3) == 0);
            send_symbol(expr_buf[i], last);
        end
        n_expr++;
    endtask

    task automatic load_text(string s);
        expr_buf.delete();
        for (int i = 0; i < s.len(); i++)
        begin
            expr_buf.push_back(s[i]);
        end
    endtask

    function automatic logic [7:0] pick_operand();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10)
        begin
            return 8'("0" + r);
        end
        if (r < 36)
        begin
            return 8'("A" + r - 10);
        end
        return 8'("a" + r - 36);
    endfunction

    function automatic logic [7:0] pick_op();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1:    c = itac_pkg::CH_PLUS;
            2, 3:    c = itac_pkg::CH_MINUS;
            4, 5:    c = itac_pkg::CH_STAR;
            6, 7:    c = itac_pkg::CH_SLASH;
            default:
            begin
                // any other byte acts as a lowest-rank operator
                do
                begin
                    c = 8'($urandom_range(0, 255));
                end
                while (tac_scoreboard::is_var_char(c) || c == itac_pkg::CH_LPAREN ||
                       c == itac_pkg::CH_RPAREN);
            end
        endcase
        return c;
    endfunction

    task automatic build_expr();
        int n_opnd;
        int depth;
        expr_buf.delete();
        expr_buf.push_back(pick_operand());
        expr_buf.push_back("=");
        n_opnd = $urandom_range(1, 10);
        depth = 0;
        for (int i = 0; i < n_opnd; i++)
        begin
            if (i > 0)
            begin
                expr_buf.push_back(pick_op());
            end
            while (depth < 5 && $urandom_range(0, 4) == 0)
            begin
                expr_buf.push_back(itac_pkg::CH_LPAREN);
                depth++;
            end
            expr_buf.push_back(pick_operand());
            while (depth > 0 && $urandom_range(0, 2) == 0)
            begin
                expr_buf.push_back(itac_pkg::CH_RPAREN);
                depth--;
            end
        end
        // sometimes leave open parentheses for the flush to drop
        if ($urandom_range(0, 3) != 0)
        begin
            repeat (depth) expr_buf.push_back(itac_pkg::CH_RPAREN);
        end
    endtask

    task automatic break_expr();
        int pos;
        pos = $urandom_range(2, expr_buf.size() - 1);
        case ($urandom_range(0, 3))
            0: expr_buf[pos] = 8'($urandom_range(0, 255));
            1: expr_buf.delete(pos);
            2: expr_buf.insert(pos, $urandom_range(0, 1) ? itac_pkg::CH_RPAREN : pick_op());
            default:
            begin
                while (expr_buf.size() > pos)
                begin
                    void'(expr_buf.pop_back());
                end
            end
        endcase
    endtask

    initial
    begin : stim
        int rand_base;
        int pick;
        sym_if.valid = 1'b0;
        sym_if.symbol = 8'h00;
        sym_if.is_last = 1'b0;
        rst_n = 1'b0;
        idle_on = 1'b1;
        n_sent = 0;
        n_expr = 0;
        quiet_cycles = 0;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-character and two-character expressions, then A=B+C*D
        expr_buf = '{8'hFF};
        send_expr(1'b0);
        load_text("Q=");
        send_expr(1'b0);
        load_text("A=B+C*D");
        send_expr(1'b0);
        // unmatched close parenthesis
        load_text("a=(9-z)/0)");
        send_expr(1'b0);
        // too few operands at the flush
        load_text("T=+");
        send_expr(1'b0);
        // zero byte as an operator, open parenthesis left at the end
        expr_buf = '{"m", "=", itac_pkg::CH_LPAREN, "5", 8'h00, "6"};
        send_expr(1'b0);

        // operand stack overflow, then ignored characters
        load_text("A=");
        repeat (itac_pkg::OPERAND_DEPTH + 1) expr_buf.push_back(pick_operand());
        expr_buf.push_back(itac_pkg::CH_PLUS);
        expr_buf.push_back("B");
        send_expr(1'b0);
        // operator stack overflow
        load_text("A=");
        repeat (itac_pkg::OPERATOR_DEPTH + 1) expr_buf.push_back(itac_pkg::CH_LPAREN);
        expr_buf.push_back("B");
        send_expr(1'b0);

        rand_base = n_sent;
        while (n_sent - rand_base < RANDOM_ITEMS)
        begin
            if (n_sent - rand_base > CALM_AFTER)
            begin
                idle_on = 1'b0;
            end
            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                build_expr();
                send_expr(1'b0);
            end
            else if (pick < 17)
            begin
                build_expr();
                break_expr();
                send_expr(1'b0);
            end
            else
            begin
                expr_buf.delete();
                repeat ($urandom_range(1, 8)) expr_buf.push_back(8'($urandom_range(0, 255)));
                send_expr(1'b1);
            end
        end
        sym_if.valid <= 1'b0;

        while (sb.outstanding() > 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("tb_top: %0d characters in %0d expressions sent", n_sent, n_expr);
        $display("tb_top: checked %0d instructions, %0d final assignments, %0d error results",
                 sb.n_insn, sb.n_final, sb.n_fault);
        if (sb.errors == 0 && sb.outstanding() == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
